FILE: src/rrq_pkg.sv
// ----------------------------------------------------------------------------
// rrq_pkg
// Shared types and constants for the round-robin ready queue.
// ----------------------------------------------------------------------------
package rrq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_WIDTH    = 16;

    // port field widths
    localparam int OP_W      = 3;
    localparam int TID_W     = 16;
    localparam int RES_W     = 16;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 5;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_GET    = 3'd2,
        OP_NEXT   = 3'd3,
        OP_SETCUR = 3'd4,
        OP_SEARCH = 3'd5
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // per-cell control from the queue controller
    typedef struct packed {
        logic load;   // take the inserted id
        logic shift;  // take the neighbor's id (close a gap)
    } t_cell_ctl;

endpackage

FILE: src/rrq_cell.sv
// ----------------------------------------------------------------------------
// rrq_cell
// One slot of the queue: holds an id, compares it with the search key and
// takes either a new id or its upper neighbor's id.
// ----------------------------------------------------------------------------
module rrq_cell import rrq_pkg::*; #(
    parameter int ID_WIDTH = DEF_ID_WIDTH
) (
    input  logic                i_clk,
    input  t_cell_ctl           i_ctl,
    input  logic [ID_WIDTH-1:0] i_ins_id,
    input  logic [ID_WIDTH-1:0] i_nbr_id,
    input  logic [ID_WIDTH-1:0] i_key,
    output logic [ID_WIDTH-1:0] o_id,
    output logic                o_match
);

    logic [ID_WIDTH-1:0] r_id;
    logic [ID_WIDTH-1:0] n_id;

    always_comb begin
        n_id = r_id;
        if (i_ctl.load) begin
            n_id = i_ins_id;
        end else if (i_ctl.shift) begin
            n_id = i_nbr_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

    assign o_id    = r_id;
    assign o_match = (r_id == i_key);

endmodule

FILE: src/round_robin_ready_queue_core.sv
// ----------------------------------------------------------------------------
// round_robin_ready_queue_core
// Ordered ring of thread ids with insert, remove, get, round-robin next,
// set-cursor and search, built as a row of id cells.
// ----------------------------------------------------------------------------
// Each operation word is done in one pass: every cell compares its id with
// the key at once, a priority pick finds the first live match, and on a
// removal every cell at or above the hole takes its upper neighbor's id in
// the same edge. The result word lands in an output register, and a new
// operation is taken whenever that register is empty or being drained, so
// the queue sustains one operation per cycle; the result word is valid in
// the cycle after acceptance. The critical path is set by the key compare
// plus the first-match priority pick across QUEUE_DEPTH cells.
// No clearing pass is needed after reset: cells beyond the count are never
// read.
module round_robin_ready_queue_core import rrq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH    = DEF_ID_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // operation stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [2:0] operation, [18:3] thread_id, [23:19] zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [15:0] result_id, [17:16] status, [22:18] entry_count, [23] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int CW  = $clog2(QUEUE_DEPTH + 1); // count width
    localparam int CIW = $clog2(QUEUE_DEPTH);     // slot index width

    // queue state
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic [CIW-1:0] r_cur;
    logic [CIW-1:0] n_cur;

    // output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // decoded input word
    t_op                 w_op;
    logic [ID_WIDTH-1:0] w_key;
    logic                w_accept;

    // cell row
    t_cell_ctl           w_ctl  [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0] w_ids  [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0] w_nbr  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_match;
    logic [QUEUE_DEPTH-1:0] w_hit;

    // operation decode results
    logic                w_found;
    logic [CIW-1:0]      w_at;
    logic                w_ins_en;
    logic                w_drop_en;
    logic [CIW-1:0]      w_drop_idx;
    logic [ID_WIDTH-1:0] w_res;
    t_status             w_st;
    logic [CIW:0]        w_cur_inc;
    logic [CIW-1:0]      w_cur_nxt;
    logic [CW-1:0]       w_cnt_dec;

    assign w_op     = t_op'(i_s_axis_tdata[OP_W-1:0]);
    assign w_key    = ID_WIDTH'(i_s_axis_tdata[OP_W+TID_W-1:OP_W]);
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    // cells, chained from the back toward the front
    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        if (k == QUEUE_DEPTH - 1) begin : g_last
            assign w_nbr[k] = '0;
        end else begin : g_mid
            assign w_nbr[k] = w_ids[k+1];
        end

        assign w_hit[k] = w_match[k] && (CW'(k) < r_count);

        always_comb begin
            w_ctl[k].load  = w_accept && w_ins_en && (CW'(k) == r_count);
            w_ctl[k].shift = w_accept && w_drop_en && (CIW'(k) >= w_drop_idx);
        end

        rrq_cell #(
            .ID_WIDTH (ID_WIDTH)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl[k]),
            .i_ins_id (w_key),
            .i_nbr_id (w_nbr[k]),
            .i_key    (w_key),
            .o_id     (w_ids[k]),
            .o_match  (w_match[k])
        );
    end

    // first live match from the front
    always_comb begin
        w_at = '0;
        for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
            if (w_hit[k]) begin
                w_at = CIW'(k);
            end
        end
    end
    assign w_found = |w_hit;

    // round-robin step, wraps to the front at the count
    assign w_cur_inc = (CIW+1)'(r_cur) + (CIW+1)'(1);
    assign w_cur_nxt = (w_cur_inc >= (CIW+1)'(r_count)) ? '0 : w_cur_inc[CIW-1:0];
    assign w_cnt_dec = r_count - CW'(1);

    // operation decode
    always_comb begin
        w_ins_en   = 1'b0;
        w_drop_en  = 1'b0;
        w_drop_idx = '0;
        w_res      = '0;
        w_st       = ST_OK;
        n_count    = r_count;
        n_cur      = r_cur;
        case (w_op)
            OP_INSERT: begin
                if (r_count >= CW'(QUEUE_DEPTH)) begin
                    w_st = ST_FULL;
                end else begin
                    w_ins_en = 1'b1;
                    n_count  = r_count + CW'(1);
                end
            end
            OP_REMOVE: begin
                if (r_count == '0) begin
                    w_st = ST_EMPTY;
                end else if (!w_found) begin
                    w_st = ST_NOTFOUND;
                end else begin
                    w_res      = w_key;
                    w_drop_en  = 1'b1;
                    w_drop_idx = w_at;
                end
            end
            OP_GET: begin
                if (r_count == '0) begin
                    w_st = ST_EMPTY;
                end else begin
                    w_res      = w_ids[0];
                    w_drop_en  = 1'b1;
                    w_drop_idx = '0;
                end
            end
            OP_NEXT: begin
                if (r_count == '0) begin
                    w_st = ST_EMPTY;
                end else begin
                    n_cur = w_cur_nxt;
                    w_res = w_ids[w_cur_nxt];
                end
            end
            OP_SETCUR: begin
                if (r_count == '0) begin
                    w_st  = ST_EMPTY;
                    n_cur = '0;
                end else begin
                    n_cur = w_cnt_dec[CIW-1:0];
                end
            end
            OP_SEARCH: begin
                if (r_count == '0) begin
                    w_st = ST_EMPTY;
                end else if (!w_found) begin
                    w_st = ST_NOTFOUND;
                end else begin
                    w_res = w_key;
                end
            end
            default: begin
            end
        endcase

        // removal: shrink, pull the cursor back if the hole was at or before it
        if (w_drop_en) begin
            n_count = w_cnt_dec;
            if (w_cnt_dec == '0) begin
                n_cur = '0;
            end else begin
                if (w_drop_idx <= r_cur) begin
                    n_cur = (r_cur == '0) ? CIW'(w_cnt_dec - CW'(1)) : r_cur - CIW'(1);
                end
                if (CW'(n_cur) >= w_cnt_dec) begin
                    n_cur = CIW'(w_cnt_dec - CW'(1));
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cur   <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
            r_cur   <= n_cur;
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {1'b0, CNT_OUT_W'(n_count), w_st, RES_W'(w_res)};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    // count never exceeds the number of cells
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    // cursor stays on a live slot, or at the front when empty
    a_cursor_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) ? (r_cur == '0) : (CW'(r_cur) < r_count))
        else $error("cursor off the live entries");

    // an accepted word always yields a result word in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted word produced no result");

    // count holds when no word is accepted (the step per accepted word is not checked here)
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_count))
        else $error("count changed without an operation");
`endif

endmodule
